// File: rtl/cfd_pkg.sv
// cfd_pkg: shared constants, types and helpers of the command frame decoder
// no dependencies; used by cfd_front, cfd_frame_q, cfd_back and the top level
package cfd_pkg;

  // frame geometry
  localparam int FRAME_BYTES = 16;
  localparam int STORE_DEPTH = FRAME_BYTES - 3;
  localparam int PHASE_W     = $clog2(FRAME_BYTES);
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // queue geometry, shared by the frame queue and the result queue
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // header bytes
  localparam logic [7:0] HDR_FIRST  = 8'hA5;
  localparam logic [7:0] HDR_SECOND = 8'h5A;

  // command codes
  localparam logic [7:0] CMD_NONE = 8'd0;
  localparam logic [7:0] CMD_MAX  = 8'd7;
  localparam logic [2:0] CMD_WALK = 3'd3;
  localparam logic [2:0] CMD_GOTO = 3'd4;
  localparam logic [2:0] CMD_POSE = 3'd5;
  localparam logic [2:0] CMD_MOVE = 3'd7;

  typedef logic [7:0] store_t [STORE_DEPTH];

  // one classified frame, front to back
  typedef struct packed {
    logic [2:0]  cmd;
    logic        ok;
    logic [15:0] w3;
    logic [15:0] w5;
    logic [15:0] w7;
    logic [15:0] w9;
    logic [7:0]  b9;
    logic [7:0]  b10;
    logic [7:0]  b11;
    logic [7:0]  b12;
  } frame_rec_t;

  // one result request
  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [7:0]  speed;
    logic [7:0]  duration;
    logic [7:0]  waypoint;
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic        checksum_ok;
  } result_t;

  // frame byte k; bytes outside the stored part of the frame read as zero
  function automatic logic [7:0] frame_byte(input store_t s, input int k);
    logic [7:0] v;
    v = 8'h00;
    if (k >= 2 && k <= FRAME_BYTES - 2) begin
      v = s[k-2];
    end
    return v;
  endfunction

  // big-endian word starting at frame byte k
  function automatic logic [15:0] frame_word(input store_t s, input int k);
    return {frame_byte(s, k), frame_byte(s, k + 1)};
  endfunction

endpackage

// File: rtl/cfd_front.sv
// cfd_front: header hunt, byte collection, running sum and frame classification
// depends on cfd_pkg; pushes frame records into cfd_frame_q
module cfd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [7:0]          in_rx_byte,
  input  logic                fq_full,
  output logic                fq_push,
  output cfd_pkg::frame_rec_t fq_rec
);

  typedef enum logic [2:0] {
    ST_HUNT = 3'b001,
    ST_HDR  = 3'b010,
    ST_BODY = 3'b100
  } fstate_t;

  fstate_t                       state_r, state_nxt;
  logic [cfd_pkg::PHASE_W-1:0]   phase_r, phase_nxt;
  logic [7:0]                    sum_r, sum_nxt;
  cfd_pkg::store_t               store_r;
  logic                          accept;
  logic                          last;
  logic                          store_we;
  logic [cfd_pkg::STORE_AW-1:0]  store_idx;
  logic [7:0]                    cmd_byte;
  logic                          cmd_known;

  // a byte is taken whenever the frame queue has room
  assign in_full = fq_full;
  assign accept  = in_push & ~in_full;
  assign last    = (phase_r == cfd_pkg::PHASE_W'(cfd_pkg::FRAME_BYTES - 1));
  assign store_idx = cfd_pkg::STORE_AW'(phase_r - cfd_pkg::PHASE_W'(2));

  // classify the collected frame
  assign cmd_byte  = cfd_pkg::frame_byte(store_r, 2);
  assign cmd_known = (cmd_byte != cfd_pkg::CMD_NONE) && (cmd_byte <= cfd_pkg::CMD_MAX);

  always_comb begin
    fq_rec.cmd = cmd_byte[2:0];
    fq_rec.ok  = (sum_r == in_rx_byte);
    fq_rec.w3  = cfd_pkg::frame_word(store_r, 3);
    fq_rec.w5  = cfd_pkg::frame_word(store_r, 5);
    fq_rec.w7  = cfd_pkg::frame_word(store_r, 7);
    fq_rec.w9  = cfd_pkg::frame_word(store_r, 9);
    fq_rec.b9  = cfd_pkg::frame_byte(store_r, 9);
    fq_rec.b10 = cfd_pkg::frame_byte(store_r, 10);
    fq_rec.b11 = cfd_pkg::frame_byte(store_r, 11);
    fq_rec.b12 = cfd_pkg::frame_byte(store_r, 12);
  end

  // frame phase tracking
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    store_we  = 1'b0;
    fq_push   = 1'b0;
    unique case (state_r)
      ST_HUNT: begin
        if (accept && in_rx_byte == cfd_pkg::HDR_FIRST) begin
          state_nxt = ST_HDR;
          sum_nxt   = cfd_pkg::HDR_FIRST;
        end
      end
      ST_HDR: begin
        if (accept) begin
          if (in_rx_byte == cfd_pkg::HDR_SECOND) begin
            state_nxt = ST_BODY;
            phase_nxt = cfd_pkg::PHASE_W'(2);
            sum_nxt   = sum_r + in_rx_byte;
          end else if (in_rx_byte == cfd_pkg::HDR_FIRST) begin
            sum_nxt = cfd_pkg::HDR_FIRST;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_BODY: begin
        if (accept) begin
          if (!last) begin
            store_we  = 1'b1;
            sum_nxt   = sum_r + in_rx_byte;
            phase_nxt = phase_r + cfd_pkg::PHASE_W'(1);
          end else begin
            state_nxt = ST_HUNT;
            fq_push   = cmd_known;
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      phase_r <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // frame byte store
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[store_idx] <= in_rx_byte;
    end
  end

endmodule

// File: rtl/cfd_frame_q.sv
// cfd_frame_q: short queue of classified frames between front and back
// depends on cfd_pkg
module cfd_frame_q (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cfd_pkg::frame_rec_t push_rec,
  output logic                full,
  input  logic                pop,
  output cfd_pkg::frame_rec_t pop_rec,
  output logic                empty
);

  cfd_pkg::frame_rec_t         mem_r [cfd_pkg::Q_DEPTH];
  logic [cfd_pkg::Q_AW-1:0]    wptr_r, wptr_nxt;
  logic [cfd_pkg::Q_AW-1:0]    rptr_r, rptr_nxt;
  logic [cfd_pkg::Q_CW-1:0]    count_r, count_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (count_r == cfd_pkg::Q_CW'(cfd_pkg::Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign pop_rec = mem_r[rptr_r];

  // pointer and count update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == cfd_pkg::Q_AW'(cfd_pkg::Q_DEPTH - 1)) ? '0
                 : wptr_r + cfd_pkg::Q_AW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == cfd_pkg::Q_AW'(cfd_pkg::Q_DEPTH - 1)) ? '0
                 : rptr_r + cfd_pkg::Q_AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + cfd_pkg::Q_CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - cfd_pkg::Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_rec;
    end
  end

endmodule

// File: rtl/cfd_back.sv
// cfd_back: applies frame commands to the retained fields and queues results
// depends on cfd_pkg; takes frame records from cfd_frame_q
module cfd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fq_empty,
  input  cfd_pkg::frame_rec_t fq_rec,
  output logic                fq_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output cfd_pkg::result_t    out_res
);

  logic [15:0]               pos_x_r, pos_x_nxt;
  logic [15:0]               pos_y_r, pos_y_nxt;
  logic [15:0]               pos_z_r, pos_z_nxt;
  logic [15:0]               roll_r, roll_nxt;
  logic [15:0]               pitch_r, pitch_nxt;
  logic [15:0]               yaw_r, yaw_nxt;
  logic [7:0]                speed_r, speed_nxt;
  logic [7:0]                dur_r, dur_nxt;
  logic [7:0]                wpt_r, wpt_nxt;

  cfd_pkg::result_t          oq_mem_r [cfd_pkg::Q_DEPTH];
  logic [cfd_pkg::Q_AW-1:0]  oq_wptr_r, oq_wptr_nxt;
  logic [cfd_pkg::Q_AW-1:0]  oq_rptr_r, oq_rptr_nxt;
  logic [cfd_pkg::Q_CW-1:0]  oq_count_r, oq_count_nxt;
  logic                      oq_full;
  logic                      oq_pop;
  cfd_pkg::result_t          res;

  // take a frame whenever the result queue has room
  assign oq_full = (oq_count_r == cfd_pkg::Q_CW'(cfd_pkg::Q_DEPTH));
  assign fq_pop  = ~fq_empty & ~oq_full;

  // retained field update per command
  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    roll_nxt  = roll_r;
    pitch_nxt = pitch_r;
    yaw_nxt   = yaw_r;
    speed_nxt = speed_r;
    dur_nxt   = dur_r;
    wpt_nxt   = wpt_r;
    unique case (fq_rec.cmd)
      cfd_pkg::CMD_WALK: begin
        pos_x_nxt = fq_rec.w3;
        pos_y_nxt = fq_rec.w5;
        pos_z_nxt = fq_rec.w7;
        speed_nxt = fq_rec.b9;
      end
      cfd_pkg::CMD_GOTO: begin
        pos_x_nxt = fq_rec.w3;
        pos_y_nxt = fq_rec.w5;
        pos_z_nxt = fq_rec.w7;
        dur_nxt   = fq_rec.b9;
        wpt_nxt   = fq_rec.b10;
      end
      cfd_pkg::CMD_MOVE: begin
        pos_x_nxt = fq_rec.w3;
        pos_y_nxt = fq_rec.w5;
        pos_z_nxt = fq_rec.w7;
      end
      cfd_pkg::CMD_POSE: begin
        roll_nxt  = fq_rec.w3;
        pitch_nxt = fq_rec.w5;
        yaw_nxt   = fq_rec.w7;
        pos_z_nxt = fq_rec.w9;
        dur_nxt   = fq_rec.b11;
        wpt_nxt   = fq_rec.b12;
      end
      default: begin
      end
    endcase
  end

  // result built from the updated fields
  always_comb begin
    res.command     = fq_rec.cmd;
    res.pos_x       = pos_x_nxt;
    res.pos_y       = pos_y_nxt;
    res.pos_z       = pos_z_nxt;
    res.speed       = speed_nxt;
    res.duration    = dur_nxt;
    res.waypoint    = wpt_nxt;
    res.roll        = roll_nxt;
    res.pitch       = pitch_nxt;
    res.yaw         = yaw_nxt;
    res.checksum_ok = fq_rec.ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
      roll_r  <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
      speed_r <= '0;
      dur_r   <= '0;
      wpt_r   <= '0;
    end else if (fq_pop) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
      roll_r  <= roll_nxt;
      pitch_r <= pitch_nxt;
      yaw_r   <= yaw_nxt;
      speed_r <= speed_nxt;
      dur_r   <= dur_nxt;
      wpt_r   <= wpt_nxt;
    end
  end

  // result queue control
  assign out_empty = (oq_count_r == '0);
  assign oq_pop    = out_pop & ~out_empty;
  assign out_res   = oq_mem_r[oq_rptr_r];

  always_comb begin
    oq_wptr_nxt  = oq_wptr_r;
    oq_rptr_nxt  = oq_rptr_r;
    oq_count_nxt = oq_count_r;
    if (fq_pop) begin
      oq_wptr_nxt = (oq_wptr_r == cfd_pkg::Q_AW'(cfd_pkg::Q_DEPTH - 1)) ? '0
                    : oq_wptr_r + cfd_pkg::Q_AW'(1);
    end
    if (oq_pop) begin
      oq_rptr_nxt = (oq_rptr_r == cfd_pkg::Q_AW'(cfd_pkg::Q_DEPTH - 1)) ? '0
                    : oq_rptr_r + cfd_pkg::Q_AW'(1);
    end
    if (fq_pop && !oq_pop) begin
      oq_count_nxt = oq_count_r + cfd_pkg::Q_CW'(1);
    end else if (oq_pop && !fq_pop) begin
      oq_count_nxt = oq_count_r - cfd_pkg::Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wptr_r  <= '0;
      oq_rptr_r  <= '0;
      oq_count_r <= '0;
    end else begin
      oq_wptr_r  <= oq_wptr_nxt;
      oq_rptr_r  <= oq_rptr_nxt;
      oq_count_r <= oq_count_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (fq_pop) begin
      oq_mem_r[oq_wptr_r] <= res;
    end
  end

endmodule

// File: rtl/command_frame_decoder.sv
// Command frame decoder. Takes one received byte per clock while in_full is low,
// hunts for the header A5 5A and collects a 16-byte frame (header, command,
// twelve payload bytes, sum checksum). A frame with command 1 to 7 yields one
// result holding the command, all retained position, angle and small fields
// (updated first by commands 3, 4, 5 and 7) and a checksum flag; other commands yield nothing.
// Rate: one byte per cycle while in_full is low. With both queues empty, a
// frame record is registered into the frame queue as its checksum byte is
// accepted, then its result is registered into the result queue for the output.
// full rises only when the two-entry frame queue
// between the byte front end and the command back end is full, which happens
// when results are not popped; a frame is at least 16 bytes, so a
// consumer that pops once per frame never stalls the byte stream.
// depends on cfd_pkg, cfd_front, cfd_frame_q, cfd_back
module command_frame_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_rx_byte,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [2:0]         out_command,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic signed [15:0] out_pos_z,
  output logic signed [7:0]  out_speed,
  output logic signed [7:0]  out_duration,
  output logic signed [7:0]  out_waypoint,
  output logic signed [15:0] out_roll_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle,
  output logic               out_checksum_ok
);

  logic                fq_full;
  logic                fq_push;
  logic                fq_empty;
  logic                fq_pop;
  cfd_pkg::frame_rec_t fq_push_rec;
  cfd_pkg::frame_rec_t fq_pop_rec;
  cfd_pkg::result_t    res;

  // byte front end
  cfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_rx_byte (in_rx_byte),
    .fq_full    (fq_full),
    .fq_push    (fq_push),
    .fq_rec     (fq_push_rec)
  );

  // frame queue
  cfd_frame_q u_frame_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fq_push),
    .push_rec (fq_push_rec),
    .full     (fq_full),
    .pop      (fq_pop),
    .pop_rec  (fq_pop_rec),
    .empty    (fq_empty)
  );

  // command back end
  cfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fq_empty  (fq_empty),
    .fq_rec    (fq_pop_rec),
    .fq_pop    (fq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (res)
  );

  // result fields
  assign out_command     = res.command;
  assign out_pos_x       = $signed(res.pos_x);
  assign out_pos_y       = $signed(res.pos_y);
  assign out_pos_z       = $signed(res.pos_z);
  assign out_speed       = $signed(res.speed);
  assign out_duration    = $signed(res.duration);
  assign out_waypoint    = $signed(res.waypoint);
  assign out_roll_angle  = $signed(res.roll);
  assign out_pitch_angle = $signed(res.pitch);
  assign out_yaw_angle   = $signed(res.yaw);
  assign out_checksum_ok = res.checksum_ok;

endmodule
